@@ hdl/tkdpe_pkg.sv @@
// Shared types and constants for the three-key debounce and press event block.
`default_nettype none
package tkdpe_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned NumSlots = 3;

  localparam logic [CfgW-1:0] DebounceReset = 16'd30;
  localparam logic [CfgW-1:0] LongReset     = 16'd800;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_POP    = 2'd1,
    REQ_WAKE   = 2'd2,
    REQ_SLEEP  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    EVT_NONE       = 3'd0,
    EVT_UP_SHORT   = 3'd1,
    EVT_DOWN_SHORT = 3'd2,
    EVT_MID_SHORT  = 3'd3,
    EVT_MID_LONG   = 3'd4
  } evt_t;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_LONG     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic short_req;
    logic long_req;
  } key_evt_t;

  typedef struct packed {
    logic [NumSlots-1:0]       en;
    evt_t [NumSlots-1:0]       code;
  } push_t;

endpackage
`default_nettype wire

@@ hdl/tkdpe_in_if.sv @@
// Request channel interface: valid/ready handshake plus request word.
`default_nettype none
interface tkdpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] now_ms;
  logic        up_level;
  logic        mid_level;
  logic        down_level;
  logic        up_wake;
  logic        mid_wake;
  logic        down_wake;

  modport source (
    output valid, req_type, now_ms, up_level, mid_level, down_level,
           up_wake, mid_wake, down_wake,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_ms, up_level, mid_level, down_level,
           up_wake, mid_wake, down_wake,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/tkdpe_out_if.sv @@
// Result channel interface: valid/ready handshake plus event word.
`default_nettype none
interface tkdpe_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [2:0] event_code;

  modport source (
    output valid, event_valid, event_code,
    input  ready
  );
  modport sink (
    input  valid, event_valid, event_code,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/tkdpe_key.sv @@
// Debounce and press timing state for one key.
`default_nettype none
module tkdpe_key (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire tkdpe_pkg::req_t            req,
  input  wire logic [31:0]                now_ms,
  input  wire logic                       pressed,
  input  wire logic                       wake,
  input  wire logic                       mid_mode,
  input  wire logic [15:0]                debounce_time,
  input  wire logic [15:0]                long_press_time,
  output tkdpe_pkg::key_evt_t             evt
);
  import tkdpe_pkg::*;

  logic             raw_r, raw_nxt;
  logic             stable_r, stable_nxt;
  logic             long_r, long_nxt;
  logic [TimeW-1:0] pst_r, pst_nxt;
  logic [TimeW-1:0] lct_r, lct_nxt;

  logic [TimeW-1:0] lct_s;
  logic [TimeW-1:0] held;
  logic             deb_ok;
  logic             edge_hit;
  logic             edge_press;
  logic             stable_a;
  logic             long_a;
  logic             due;
  logic             long_chk;

  always_comb begin
    lct_s      = (pressed != raw_r) ? now_ms : lct_r;
    deb_ok     = (now_ms - lct_s) >= {16'd0, debounce_time};
    edge_hit   = deb_ok && (stable_r != pressed);
    edge_press = edge_hit && pressed;
    stable_a   = edge_hit ? pressed : stable_r;
    long_a     = edge_press ? 1'b0 : long_r;
    held       = edge_press ? '0 : (now_ms - pst_r);
    due        = stable_a && !long_a && (held >= {16'd0, long_press_time});
    long_chk   = mid_mode ? 1'b1 : (deb_ok && !edge_hit);

    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    long_nxt   = long_r;
    pst_nxt    = pst_r;
    lct_nxt    = lct_r;
    evt        = '0;

    unique case (req)
      REQ_SAMPLE: begin
        raw_nxt    = pressed;
        lct_nxt    = lct_s;
        stable_nxt = stable_a;
        long_nxt   = (long_chk && due) ? 1'b1 : long_a;
        pst_nxt    = edge_press ? now_ms : pst_r;
        evt.short_req = edge_hit && !pressed && !long_r;
        evt.long_req  = mid_mode && due;
      end
      REQ_WAKE: begin
        if (wake) begin
          raw_nxt    = 1'b1;
          stable_nxt = 1'b1;
          long_nxt   = 1'b0;
          pst_nxt    = now_ms;
          lct_nxt    = now_ms;
        end
      end
      REQ_SLEEP: begin
        raw_nxt    = pressed;
        stable_nxt = pressed;
        long_nxt   = 1'b0;
        pst_nxt    = pressed ? now_ms : '0;
        lct_nxt    = now_ms;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      long_r   <= 1'b0;
      pst_r    <= '0;
      lct_r    <= '0;
    end else if (en) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      long_r   <= long_nxt;
      pst_r    <= pst_nxt;
      lct_r    <= lct_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tkdpe_queue.sv @@
// Ring event queue: up to three pushes and one pop per word, drops when full.
`default_nettype none
module tkdpe_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire tkdpe_pkg::push_t push,
  input  wire logic             pop,
  input  wire logic             clear,
  output logic                  pop_valid,
  output tkdpe_pkg::evt_t       pop_code
);
  import tkdpe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  evt_t           mem_r [DEPTH];
  logic [PW-1:0]  head_r, head_nxt;
  logic [PW-1:0]  tail_r, tail_nxt;
  logic [PW-1:0]  t_step;
  logic [NumSlots-1:0]        wr_en;
  logic [NumSlots-1:0][PW-1:0] wr_addr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    pop_valid = head_r != tail_r;
    pop_code  = pop_valid ? mem_r[head_r] : EVT_NONE;
    head_nxt  = head_r;
    t_step    = tail_r;
    wr_en     = '0;
    wr_addr   = '0;
    for (int s = 0; s < NumSlots; s++) begin
      wr_addr[s] = t_step;
      if (push.en[s] && (ptr_inc(t_step) != head_r)) begin
        wr_en[s] = 1'b1;
        t_step   = ptr_inc(t_step);
      end
    end
    tail_nxt = t_step;
    if (pop && pop_valid) begin
      head_nxt = ptr_inc(head_r);
    end
    if (clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (en) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NumSlots; s++) begin
        if (wr_en[s]) begin
          mem_r[wr_addr[s]] <= push.code[s];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/three_key_debounce_press_events_core.sv @@
// Top level: three-key debounce with short/long press event queue.
// Takes one request word per clock while the result channel is not stalled
// and returns exactly one result word for each. A word goes from the input
// register through the key update and queue logic into the result register,
// and the key and queue state is updated in that single pass. Sample queues
// events up, then down, then mid; up to three events may be queued by one
// sample and new events are dropped while the queue holds QUEUE_DEPTH-1
// entries. Pop returns the oldest event, wake recovery loads held keys as
// pressed, and prepare for sleep empties the queue and reloads the keys
// from their current levels. Config writes are taken at any clock with
// cfg_we high.
`default_nettype none
module three_key_debounce_press_events_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  tkdpe_in_if.sink          in_ch,
  tkdpe_out_if.source       out_ch,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import tkdpe_pkg::*;

  logic [CfgW-1:0] deb_r;
  logic [CfgW-1:0] long_r;

  logic        s1_valid_r;
  req_t        s1_req_r;
  logic [31:0] s1_now_r;
  logic [2:0]  s1_press_r;
  logic [2:0]  s1_wake_r;

  logic        out_valid_r;
  logic        out_evt_valid_r;
  evt_t        out_code_r;

  logic        advance;
  key_evt_t    up_evt, mid_evt, down_evt;
  push_t       push;
  logic        pop_valid;
  evt_t        pop_code;
  logic        is_pop;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign is_pop       = s1_req_r == REQ_POP;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_valid = out_evt_valid_r;
  assign out_ch.event_code  = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DebounceReset;
      long_r <= LongReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: deb_r  <= cfg_data;
        CFG_LONG:     long_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_r   <= req_t'(in_ch.req_type);
      s1_now_r   <= in_ch.now_ms;
      s1_press_r <= {!in_ch.down_level, !in_ch.mid_level, !in_ch.up_level};
      s1_wake_r  <= {in_ch.down_wake, in_ch.mid_wake, in_ch.up_wake};
    end
  end

  tkdpe_key u_key_up (
    .clk, .rst_n, .en(advance), .req(s1_req_r), .now_ms(s1_now_r),
    .pressed(s1_press_r[0]), .wake(s1_wake_r[0]), .mid_mode(1'b0),
    .debounce_time(deb_r), .long_press_time(long_r), .evt(up_evt)
  );

  tkdpe_key u_key_mid (
    .clk, .rst_n, .en(advance), .req(s1_req_r), .now_ms(s1_now_r),
    .pressed(s1_press_r[1]), .wake(s1_wake_r[1]), .mid_mode(1'b1),
    .debounce_time(deb_r), .long_press_time(long_r), .evt(mid_evt)
  );

  tkdpe_key u_key_down (
    .clk, .rst_n, .en(advance), .req(s1_req_r), .now_ms(s1_now_r),
    .pressed(s1_press_r[2]), .wake(s1_wake_r[2]), .mid_mode(1'b0),
    .debounce_time(deb_r), .long_press_time(long_r), .evt(down_evt)
  );

  // push order: up, down, mid
  always_comb begin
    push.en[0]   = up_evt.short_req;
    push.code[0] = EVT_UP_SHORT;
    push.en[1]   = down_evt.short_req;
    push.code[1] = EVT_DOWN_SHORT;
    push.en[2]   = mid_evt.short_req || mid_evt.long_req;
    push.code[2] = mid_evt.long_req ? EVT_MID_LONG : EVT_MID_SHORT;
  end

  tkdpe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk, .rst_n, .en(advance), .push,
    .pop(is_pop), .clear(s1_req_r == REQ_SLEEP),
    .pop_valid, .pop_code
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_evt_valid_r <= is_pop && pop_valid;
      out_code_r      <= (is_pop && pop_valid) ? pop_code : EVT_NONE;
    end
  end

endmodule
`default_nettype wire
